// ----- hdl/ipv6_route_table_lpm_defines.svh -----
// ----------------------------------------------------------------------------
// Route table assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IPV6_ROUTE_TABLE_LPM_DEFINES_SVH
`define IPV6_ROUTE_TABLE_LPM_DEFINES_SVH

`ifndef SYNTHESIS
// Check b in the same cycle as a
`define RT_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("route table check failed");
// Check b in the cycle after a
`define RT_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("route table check failed");
`else
`define RT_ASSERT_NOW(label, clk, rst_n, a, b)
`define RT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ----- hdl/rtlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Route table package
// Shared types, action codes and helpers for the IPv6 route table.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

  localparam int TableEntriesDef = 16;

  // Action codes
  localparam logic [2:0] ACT_LOOKUP = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Read address sources
  localparam logic [1:0] SRC_SCAN  = 2'd0;
  localparam logic [1:0] SRC_LAST  = 2'd1;
  localparam logic [1:0] SRC_INDEX = 2'd2;

  localparam logic [7:0] MAX_PLEN = 8'd128;

  typedef struct packed {
    logic [63:0] net_h;
    logic [63:0] net_l;
    logic [63:0] gw_h;
    logic [63:0] gw_l;
    logic [7:0]  plen;
    logic [15:0] met;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       count_zero;
    logic       scan_last;
    logic       hit;
  } sts_t;

  // Mask of the top n bits of a 64-bit word
  function automatic logic [63:0] top_mask(input logic [7:0] n);
    logic [63:0] m;
    if (n >= 8'd64) begin
      m = {64{1'b1}};
    end else begin
      m = ~({64{1'b1}} >> n);
    end
    return m;
  endfunction

endpackage

// ----- hdl/rtlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Route table controller
// Sequences scan, read and commit steps of one request at a time.
// ----------------------------------------------------------------------------
module rtlpm_ctrl
  import rtlpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_RDIX = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_src = SRC_SCAN;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_action == ACT_LOOKUP || in_action == ACT_ADD ||
              in_action == ACT_DELETE) begin
            state_nxt = sts.count_zero ? S_FIN : S_SCAN;
          end else if (in_action == ACT_READ) begin
            state_nxt = S_RDIX;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = (sts.act == ACT_DELETE && sts.hit) ? S_LAST : S_FIN;
      end
      S_LAST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_LAST;
        state_nxt  = S_FIN;
      end
      S_RDIX: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_INDEX;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold result valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/rtlpm_dpath.sv -----
// ----------------------------------------------------------------------------
// Route table datapath
// Entry memory, scan evaluation, count and epoch, and result registers.
// ----------------------------------------------------------------------------
module rtlpm_dpath
  import rtlpm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_key_addr_high,
  input  logic [63:0] in_key_addr_low,
  input  logic [7:0]  in_prefix_length,
  input  logic [63:0] in_new_gateway_high,
  input  logic [63:0] in_new_gateway_low,
  input  logic [15:0] in_route_metric,
  input  logic [3:0]  in_entry_index,
  output logic        out_success,
  output logic [63:0] out_found_network_high,
  output logic [63:0] out_found_network_low,
  output logic [63:0] out_found_gateway_high,
  output logic [63:0] out_found_gateway_low,
  output logic [7:0]  out_found_prefix_len,
  output logic [15:0] out_found_metric,
  output logic [4:0]  out_entries_in_use,
  output logic [31:0] out_change_epoch
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CountMax = CW'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q;

  // Request latched at accept
  logic [2:0]  act_r;
  entry_t      key_r;
  logic [3:0]  idx_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   epoch_r, epoch_nxt, epoch_inc;

  logic [AW-1:0] scan_idx_r, eval_idx_r, rd_addr;
  logic          scan_vld_r;

  // Scan results
  logic          best_vld_r;
  logic [7:0]    best_pl_r;
  logic [15:0]   best_met_r;
  logic [63:0]   best_gw_h_r, best_gw_l_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [63:0]   hit_gw_h_r, hit_gw_l_r;
  logic [15:0]   hit_met_r;

  logic          read_ok;
  logic          pfx_match, better, exact;
  logic [63:0]   mask_h, mask_l;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        res_nxt;
  logic          ok_nxt;

  assign read_ok = (32'(idx_r) < 32'(count_r)) && (32'(idx_r) < TABLE_ENTRIES);

  assign sts.act        = act_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.scan_last  = (CW'(scan_idx_r) == count_r - CW'(1));
  assign sts.hit        = hit_r;

  // Select read address
  always_comb begin
    case (cmd.rd_src)
      SRC_LAST:  rd_addr = AW'(count_r - CW'(1));
      SRC_INDEX: rd_addr = AW'(idx_r);
      default:   rd_addr = scan_idx_r;
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q <= mem[rd_addr];
  end

  // Compare the entry read last cycle
  always_comb begin
    mask_h    = top_mask(rd_q.plen);
    mask_l    = top_mask((rd_q.plen > 8'd64) ? rd_q.plen - 8'd64 : 8'd0);
    pfx_match = (rd_q.plen == 8'd0) ||
                ((rd_q.plen <= MAX_PLEN) &&
                 (((key_r.net_h ^ rd_q.net_h) & mask_h) == 64'd0) &&
                 (((key_r.net_l ^ rd_q.net_l) & mask_l) == 64'd0));
    better    = !best_vld_r || (rd_q.plen > best_pl_r) ||
                ((rd_q.plen == best_pl_r) && (rd_q.met < best_met_r));
    exact     = (rd_q.plen == key_r.plen) && (rd_q.net_h == key_r.net_h) &&
                (rd_q.net_l == key_r.net_l);
  end

  // Advance scan and track the best and first-exact entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      scan_vld_r <= cmd.rd_en && (cmd.rd_src == SRC_SCAN);
      if (cmd.load) begin
        best_vld_r <= 1'b0;
        hit_r      <= 1'b0;
      end else if (scan_vld_r) begin
        if (pfx_match && better) best_vld_r <= 1'b1;
        if (exact) hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx_r    <= '0;
      act_r         <= in_action;
      key_r.net_h   <= in_key_addr_high;
      key_r.net_l   <= in_key_addr_low;
      key_r.gw_h    <= in_new_gateway_high;
      key_r.gw_l    <= in_new_gateway_low;
      key_r.plen    <= in_prefix_length;
      key_r.met     <= in_route_metric;
      idx_r         <= in_entry_index;
    end else if (cmd.rd_en && cmd.rd_src == SRC_SCAN) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
    if (cmd.rd_en) eval_idx_r <= rd_addr;
    if (scan_vld_r && pfx_match && better) begin
      best_pl_r   <= rd_q.plen;
      best_met_r  <= rd_q.met;
      best_gw_h_r <= rd_q.gw_h;
      best_gw_l_r <= rd_q.gw_l;
    end
    if (scan_vld_r && exact && !hit_r) begin
      hit_idx_r  <= eval_idx_r;
      hit_gw_h_r <= rd_q.gw_h;
      hit_gw_l_r <= rd_q.gw_l;
      hit_met_r  <= rd_q.met;
    end
  end

  assign epoch_inc = (epoch_r == 32'hFFFF_FFFF) ? 32'd1 : epoch_r + 32'd1;

  // Commit the action
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = hit_idx_r;
    wr_data   = key_r;
    count_nxt = count_r;
    epoch_nxt = epoch_r;
    ok_nxt    = 1'b0;
    res_nxt   = '0;
    unique case (act_r)
      ACT_LOOKUP: begin
        if (best_vld_r) begin
          ok_nxt       = 1'b1;
          res_nxt.gw_h = best_gw_h_r;
          res_nxt.gw_l = best_gw_l_r;
          res_nxt.plen = best_pl_r;
          res_nxt.met  = best_met_r;
        end
      end
      ACT_ADD: begin
        if (hit_r) begin
          ok_nxt = 1'b1;
          if (hit_gw_h_r != key_r.gw_h || hit_gw_l_r != key_r.gw_l ||
              hit_met_r != key_r.met) begin
            wr_en     = 1'b1;
            epoch_nxt = epoch_inc;
          end
        end else if (count_r < CountMax) begin
          ok_nxt    = 1'b1;
          wr_en     = 1'b1;
          wr_addr   = AW'(count_r);
          count_nxt = count_r + CW'(1);
          epoch_nxt = epoch_inc;
        end
      end
      ACT_DELETE: begin
        if (hit_r) begin
          ok_nxt    = 1'b1;
          wr_en     = 1'b1;
          wr_data   = rd_q;
          count_nxt = count_r - CW'(1);
          epoch_nxt = epoch_inc;
        end
      end
      ACT_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
        if (count_r != '0) epoch_nxt = epoch_inc;
      end
      ACT_READ: begin
        if (read_ok) begin
          ok_nxt  = 1'b1;
          res_nxt = rd_q;
        end
      end
      default: ok_nxt = 1'b0;
    endcase
    wr_en = wr_en && cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      epoch_r <= 32'd1;
    end else if (cmd.finish) begin
      count_r <= count_nxt;
      epoch_r <= epoch_nxt;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_success            <= ok_nxt;
      out_found_network_high <= res_nxt.net_h;
      out_found_network_low  <= res_nxt.net_l;
      out_found_gateway_high <= res_nxt.gw_h;
      out_found_gateway_low  <= res_nxt.gw_l;
      out_found_prefix_len   <= res_nxt.plen;
      out_found_metric       <= res_nxt.met;
      out_entries_in_use     <= 5'(count_nxt);
      out_change_epoch       <= epoch_nxt;
    end
  end

endmodule

// ----- hdl/ipv6_route_table_lpm.sv -----
// ----------------------------------------------------------------------------
// IPv6 route table with longest-prefix match
// Bounded route table: lookup, add/update, delete, clear and read entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: an action plus key,
//   prefix length, gateway, metric and entry index. The result channel
//   (out_valid/out_ready) returns exactly one result per request.
//   Lookup, add and delete walk the stored entries one per cycle through the
//   single read port of the entry memory; a delete that hits also reads the
//   last entry, which it moves into the freed slot. One request is in
//   flight at a time; the next is taken as soon as the result is registered.
//   A stalled result holds in the output register; a finished request waits
//   before committing until that register is free.
//   Reset empties the table (count 0) and sets the change epoch to 1; the
//   entry memory is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module ipv6_route_table_lpm
  import rtlpm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_key_addr_high,
  input  logic [63:0] in_key_addr_low,
  input  logic [7:0]  in_prefix_length,
  input  logic [63:0] in_new_gateway_high,
  input  logic [63:0] in_new_gateway_low,
  input  logic [15:0] in_route_metric,
  input  logic [3:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_success,
  output logic [63:0] out_found_network_high,
  output logic [63:0] out_found_network_low,
  output logic [63:0] out_found_gateway_high,
  output logic [63:0] out_found_gateway_low,
  output logic [7:0]  out_found_prefix_len,
  output logic [15:0] out_found_metric,
  output logic [4:0]  out_entries_in_use,
  output logic [31:0] out_change_epoch
);

`include "ipv6_route_table_lpm_defines.svh"

  cmd_t cmd;
  sts_t sts;

  rtlpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtlpm_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_action              (in_action),
    .in_key_addr_high       (in_key_addr_high),
    .in_key_addr_low        (in_key_addr_low),
    .in_prefix_length       (in_prefix_length),
    .in_new_gateway_high    (in_new_gateway_high),
    .in_new_gateway_low     (in_new_gateway_low),
    .in_route_metric        (in_route_metric),
    .in_entry_index         (in_entry_index),
    .out_success            (out_success),
    .out_found_network_high (out_found_network_high),
    .out_found_network_low  (out_found_network_low),
    .out_found_gateway_high (out_found_gateway_high),
    .out_found_gateway_low  (out_found_gateway_low),
    .out_found_prefix_len   (out_found_prefix_len),
    .out_found_metric       (out_found_metric),
    .out_entries_in_use     (out_entries_in_use),
    .out_change_epoch       (out_change_epoch)
  );

  // Epoch never reads as zero
  `RT_ASSERT_NOW(a_epoch_nonzero, clk, rst_n, out_valid, out_change_epoch != 32'd0)
  // One request at a time: busy right after accept
  `RT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // Count stays within the table
  `RT_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid,
                 32'(out_entries_in_use) <= TABLE_ENTRIES)
  // A commit sets a new result: result goes valid only with the block idle
  `RT_ASSERT_NOW(a_valid_rise_idle, clk, rst_n, $rose(out_valid), in_ready)

endmodule
